@@ hw/rtl/lfmc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lfmc_pkg;

   typedef enum logic [1:0] {
      MODE_STANDBY  = 2'd0,
      MODE_TRACKING = 2'd1,
      MODE_LOST     = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      CLS_DARK    = 3'd0,
      CLS_RED     = 3'd1,
      CLS_GREEN   = 3'd2,
      CLS_BLUE    = 3'd3,
      CLS_YELLOW  = 3'd4,
      CLS_CYAN    = 3'd5,
      CLS_MAGENTA = 3'd6,
      CLS_WHITE   = 3'd7
   } class_type;

   typedef enum logic [1:0] {
      WHEEL_FWD   = 2'd0,
      WHEEL_REV   = 2'd1,
      WHEEL_BRAKE = 2'd2,
      WHEEL_COAST = 2'd3
   } wheel_type;

   typedef enum logic [1:0] {
      LAMP_NONE  = 2'd0,
      LAMP_FRONT = 2'd1,
      LAMP_REAR  = 2'd2,
      LAMP_BOTH  = 2'd3
   } lamp_type;

   localparam logic OP_TICK   = 1'b0;
   localparam logic OP_BUMPER = 1'b1;

   localparam logic [5:0]  BUMPER_START_ONLY = 6'd1;
   localparam logic [15:0] LOST_LIMIT_RESET  = 16'd750;

   localparam int unsigned REQ_DATA_W = 16;
   localparam int unsigned RSP_DATA_W = 16;

   // mode in the lowest bits, lamp pattern in the highest
   typedef struct packed {
      lamp_type  lamp_pattern;
      wheel_type right_wheel;
      wheel_type left_wheel;
      class_type rgb_shown;
      logic      indicator_on;
      class_type steer_class;
      mode_type  mode;
   } status_type;

endpackage

`default_nettype wire

@@ hw/rtl/lfmc_classify.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lfmc_classify (
   input  wire logic [7:0]         sensor_bits,
   output lfmc_pkg::class_type     steer_class
);
   import lfmc_pkg::*;

   logic [2:0] l_cnt;
   logic [2:0] r_cnt;

   assign r_cnt = {2'b00, sensor_bits[0]} + {2'b00, sensor_bits[1]}
                + {2'b00, sensor_bits[2]} + {2'b00, sensor_bits[3]};
   assign l_cnt = {2'b00, sensor_bits[4]} + {2'b00, sensor_bits[5]}
                + {2'b00, sensor_bits[6]} + {2'b00, sensor_bits[7]};

   always_comb begin
      if (l_cnt == 3'd0 && r_cnt == 3'd0) begin
         steer_class = CLS_WHITE;
      end else if ((l_cnt != 3'd0 && r_cnt == 3'd0) || l_cnt > r_cnt + 3'd1) begin
         steer_class = (r_cnt == 3'd0) ? CLS_RED : CLS_YELLOW;
      end else if ((r_cnt != 3'd0 && l_cnt == 3'd0) || r_cnt > l_cnt + 3'd1) begin
         steer_class = (l_cnt == 3'd0) ? CLS_BLUE : CLS_CYAN;
      end else begin
         steer_class = CLS_GREEN;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/lfmc_update.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lfmc_update (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step,
   input  wire logic                op,
   input  wire lfmc_pkg::class_type steer_class,
   input  wire logic [5:0]          bumper_mask,
   input  wire logic                csr_wr_en,
   input  wire logic [15:0]         csr_wr_data,
   output lfmc_pkg::status_type     status_next
);
   import lfmc_pkg::*;

   mode_type   mode_ff,  mode_in, mode_mid;
   class_type  class_ff, class_in;
   class_type  rgb_ff,   rgb_in;
   wheel_type  left_ff,  left_in;
   wheel_type  right_ff, right_in;
   lamp_type   lamp_ff,  lamp_in;
   logic       blink_ff, blink_in;
   logic       ind_ff,   ind_in;
   logic [15:0] lost_cnt_ff, lost_cnt_in;
   logic [15:0] lost_limit_ff;

   // next mode and lost timer
   always_comb begin
      mode_mid    = mode_ff;
      mode_in     = mode_ff;
      class_in    = class_ff;
      lost_cnt_in = lost_cnt_ff;
      if (op == OP_TICK) begin
         mode_mid = (mode_ff == MODE_LOST) ? MODE_TRACKING : mode_ff;
         class_in = steer_class;
         if (steer_class == CLS_WHITE && mode_mid == MODE_TRACKING) begin
            mode_mid = MODE_LOST;
         end
         if (mode_mid != MODE_LOST) begin
            lost_cnt_in = '0;
         end else if (lost_cnt_ff != '1) begin
            lost_cnt_in = lost_cnt_ff + 16'd1;
         end
         mode_in = (lost_cnt_in >= lost_limit_ff) ? MODE_STANDBY : mode_mid;
      end else begin
         if (bumper_mask == BUMPER_START_ONLY && mode_ff == MODE_STANDBY) begin
            mode_in = MODE_TRACKING;
         end else if (mode_ff == MODE_TRACKING || mode_ff == MODE_LOST) begin
            mode_in = MODE_STANDBY;
         end
      end
   end

   // drive values for the mode reached on a tick; bumper items hold them
   always_comb begin
      blink_in = blink_ff;
      ind_in   = ind_ff;
      rgb_in   = rgb_ff;
      left_in  = left_ff;
      right_in = right_ff;
      lamp_in  = lamp_ff;
      if (op == OP_TICK) begin
         unique case (mode_in)
            MODE_STANDBY: begin
               ind_in   = blink_ff;
               blink_in = ~blink_ff;
               rgb_in   = class_in;
               left_in  = WHEEL_COAST;
               right_in = WHEEL_COAST;
               lamp_in  = LAMP_NONE;
            end
            MODE_TRACKING: begin
               ind_in  = 1'b1;
               rgb_in  = class_in;
               lamp_in = LAMP_FRONT;
               case (class_in)
                  CLS_RED: begin
                     left_in  = WHEEL_REV;
                     right_in = WHEEL_FWD;
                  end
                  CLS_YELLOW: begin
                     left_in  = WHEEL_COAST;
                     right_in = WHEEL_FWD;
                  end
                  CLS_GREEN: begin
                     left_in  = WHEEL_FWD;
                     right_in = WHEEL_FWD;
                  end
                  CLS_CYAN: begin
                     left_in  = WHEEL_FWD;
                     right_in = WHEEL_COAST;
                  end
                  CLS_BLUE: begin
                     left_in  = WHEEL_FWD;
                     right_in = WHEEL_REV;
                  end
                  default: begin
                  end
               endcase
            end
            MODE_LOST: begin
               ind_in   = 1'b0;
               rgb_in   = CLS_WHITE;
               left_in  = WHEEL_REV;
               right_in = WHEEL_REV;
               lamp_in  = LAMP_REAR;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_STANDBY;
         class_ff    <= CLS_DARK;
         blink_ff    <= 1'b0;
         lost_cnt_ff <= '0;
         left_ff     <= WHEEL_COAST;
         right_ff    <= WHEEL_COAST;
         lamp_ff     <= LAMP_NONE;
         ind_ff      <= 1'b0;
         rgb_ff      <= CLS_DARK;
      end else if (step) begin
         mode_ff     <= mode_in;
         class_ff    <= class_in;
         blink_ff    <= blink_in;
         lost_cnt_ff <= lost_cnt_in;
         left_ff     <= left_in;
         right_ff    <= right_in;
         lamp_ff     <= lamp_in;
         ind_ff      <= ind_in;
         rgb_ff      <= rgb_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lost_limit_ff <= LOST_LIMIT_RESET;
      end else if (csr_wr_en) begin
         lost_limit_ff <= csr_wr_data;
      end
   end

   always_comb begin
      status_next.mode         = mode_in;
      status_next.steer_class  = class_in;
      status_next.indicator_on = ind_in;
      status_next.rgb_shown    = rgb_in;
      status_next.left_wheel   = left_in;
      status_next.right_wheel  = right_in;
      status_next.lamp_pattern = lamp_in;
   end

endmodule

`default_nettype wire

@@ hw/rtl/line_follower_mode_controller.sv @@
// an accepted item waits in the input register; its result then goes to the result register
// throughput: one item per cycle while the receiver takes results, limited by the mode and timer update
// rsp_tready low holds the result register; the input register still takes one more item
// reset (synchronous, active high) returns standby, dark, wheels coasting, lamps off,
// a cleared lost timer and a lost limit of 750
`timescale 1ns / 1ps
`default_nettype none

module line_follower_mode_controller (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output      logic                                req_tready,
   // sensor_bits [7:0], bumper_mask [13:8], zero [15:14]
   input  wire logic [lfmc_pkg::REQ_DATA_W-1:0]     req_tdata,
   // op [0]
   input  wire logic                                req_tuser,
   output      logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   // mode [1:0], steer_class [4:2], indicator_on [5], rgb_shown [8:6],
   // left_wheel [10:9], right_wheel [12:11], lamp_pattern [14:13], zero [15]
   output      logic [lfmc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  wire logic                                csr_wr_en,
   input  wire logic [15:0]                         csr_wr_data
);
   import lfmc_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic       op_ff;
   logic [7:0] sensor_ff;
   logic [5:0] bumper_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   status_type status_ff;
   status_type status_next;
   class_type  steer_class;
   logic       out_free;
   logic       step;

   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign step       = in_valid_ff & out_free;
   assign req_tready = ~in_valid_ff | out_free;

   assign in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
   assign rsp_valid_in = out_free ? in_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         op_ff     <= req_tuser;
         sensor_ff <= req_tdata[7:0];
         bumper_ff <= req_tdata[13:8];
      end
      if (step) begin
         status_ff <= status_next;
      end
   end

   lfmc_classify u_classify (
      .sensor_bits (sensor_ff),
      .steer_class (steer_class)
   );

   lfmc_update u_update (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .op          (op_ff),
      .steer_class (steer_class),
      .bumper_mask (bumper_ff),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .status_next (status_next)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, status_ff};

endmodule

`default_nettype wire

@@ hw/rtl/lfmc_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lfmc_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [lfmc_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import lfmc_pkg::*;

   // a result shows lost only after a tick, which drives the lost outputs
   a_lost_outputs: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1:0] == MODE_LOST) |->
         (rsp_tdata[5] == 1'b0 && rsp_tdata[8:6] == CLS_WHITE
          && rsp_tdata[4:2] == CLS_WHITE
          && rsp_tdata[10:9] == WHEEL_REV && rsp_tdata[12:11] == WHEEL_REV
          && rsp_tdata[14:13] == LAMP_REAR))
      else $error("lost result with wrong outputs");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result after reset");

   // a result cannot appear just after reset: an item must first pass the input register
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      ($past(reset) && !rsp_tvalid) |=> !rsp_tvalid)
      else $error("result appeared without an item");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[15] == 1'b0 && rsp_tdata[1:0] != 2'd3))
      else $error("bad result padding or mode code");

endmodule

bind line_follower_mode_controller lfmc_checker u_lfmc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

@@ dv/line_follower_mode_controller_checker.sv @@
`timescale 1ns / 1ps

module line_follower_mode_controller_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [lfmc_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                            req_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [lfmc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_wr_en,
   input  logic [15:0]                     csr_wr_data,
   output int                              outstanding,
   output int                              fail_count
);
   import lfmc_pkg::*;

   mode_type   mode_q;
   class_type  class_q;
   class_type  rgb_q;
   wheel_type  left_q;
   wheel_type  right_q;
   lamp_type   lamp_q;
   logic       blink_q;
   logic       indicator_q;
   logic [15:0] lost_cnt_q;
   logic [15:0] lost_limit_q;

   status_type want_status_q[$];

   task automatic clear_controller();
      mode_q       = MODE_STANDBY;
      class_q      = CLS_DARK;
      rgb_q        = CLS_DARK;
      left_q       = WHEEL_COAST;
      right_q      = WHEEL_COAST;
      lamp_q       = LAMP_NONE;
      blink_q      = 1'b0;
      indicator_q  = 1'b0;
      lost_cnt_q   = '0;
      lost_limit_q = LOST_LIMIT_RESET;
   endtask

   task automatic sort_sensors(input logic [7:0] sensors);
      int r_cnt;
      int l_cnt;
      r_cnt = $countones(sensors[3:0]);
      l_cnt = $countones(sensors[7:4]);
      if (mode_q == MODE_LOST) mode_q = MODE_TRACKING;
      if (l_cnt == 0 && r_cnt == 0) begin
         class_q = CLS_WHITE;
         if (mode_q == MODE_TRACKING) mode_q = MODE_LOST;
      end else if ((l_cnt > 0 && r_cnt == 0) || l_cnt > r_cnt + 1) begin
         class_q = (r_cnt == 0) ? CLS_RED : CLS_YELLOW;
      end else if ((r_cnt > 0 && l_cnt == 0) || r_cnt > l_cnt + 1) begin
         class_q = (l_cnt == 0) ? CLS_BLUE : CLS_CYAN;
      end else begin
         class_q = CLS_GREEN;
      end
   endtask

   task automatic steer_outputs();
      case (mode_q)
         MODE_STANDBY: begin
            indicator_q = blink_q;
            blink_q     = ~blink_q;
            rgb_q       = class_q;
            left_q      = WHEEL_COAST;
            right_q     = WHEEL_COAST;
            lamp_q      = LAMP_NONE;
         end
         MODE_TRACKING: begin
            indicator_q = 1'b1;
            rgb_q       = class_q;
            case (class_q)
               CLS_RED: begin
                  left_q  = WHEEL_REV;
                  right_q = WHEEL_FWD;
               end
               CLS_YELLOW: begin
                  left_q  = WHEEL_COAST;
                  right_q = WHEEL_FWD;
               end
               CLS_GREEN: begin
                  left_q  = WHEEL_FWD;
                  right_q = WHEEL_FWD;
               end
               CLS_CYAN: begin
                  left_q  = WHEEL_FWD;
                  right_q = WHEEL_COAST;
               end
               CLS_BLUE: begin
                  left_q  = WHEEL_FWD;
                  right_q = WHEEL_REV;
               end
               default: ;
            endcase
            lamp_q = LAMP_FRONT;
         end
         default: begin
            indicator_q = 1'b0;
            rgb_q       = CLS_WHITE;
            left_q      = WHEEL_REV;
            right_q     = WHEEL_REV;
            lamp_q      = LAMP_REAR;
         end
      endcase
   endtask

   task automatic step_controller(input logic op, input logic [7:0] sensors,
                                  input logic [5:0] bumpers, output status_type status);
      if (op == OP_TICK) begin
         sort_sensors(sensors);
         if (mode_q != MODE_LOST) lost_cnt_q = '0;
         else if (lost_cnt_q != 16'hFFFF) lost_cnt_q = lost_cnt_q + 16'd1;
         if (lost_cnt_q >= lost_limit_q) mode_q = MODE_STANDBY;
         steer_outputs();
      end else begin
         if (bumpers == BUMPER_START_ONLY && mode_q == MODE_STANDBY) mode_q = MODE_TRACKING;
         else if (mode_q != MODE_STANDBY) mode_q = MODE_STANDBY;
      end
      status.mode         = mode_q;
      status.steer_class  = class_q;
      status.indicator_on = indicator_q;
      status.rgb_shown    = rgb_q;
      status.left_wheel   = left_q;
      status.right_wheel  = right_q;
      status.lamp_pattern = lamp_q;
   endtask

   task automatic flag_mismatch(input string what, input int got, input int want);
      $display("%t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   task automatic check_status(input status_type got, input status_type want);
      if (got.mode != want.mode)
         flag_mismatch("mode", int'(got.mode), int'(want.mode));
      if (got.steer_class != want.steer_class)
         flag_mismatch("steer_class", int'(got.steer_class), int'(want.steer_class));
      if (got.indicator_on != want.indicator_on)
         flag_mismatch("indicator_on", int'(got.indicator_on), int'(want.indicator_on));
      if (got.rgb_shown != want.rgb_shown)
         flag_mismatch("rgb_shown", int'(got.rgb_shown), int'(want.rgb_shown));
      if (got.left_wheel != want.left_wheel)
         flag_mismatch("left_wheel", int'(got.left_wheel), int'(want.left_wheel));
      if (got.right_wheel != want.right_wheel)
         flag_mismatch("right_wheel", int'(got.right_wheel), int'(want.right_wheel));
      if (got.lamp_pattern != want.lamp_pattern)
         flag_mismatch("lamp_pattern", int'(got.lamp_pattern), int'(want.lamp_pattern));
   endtask

   always @(posedge clock) begin
      status_type got;
      status_type want;
      if (reset) begin
         clear_controller();
         want_status_q.delete();
      end else begin
         if (csr_wr_en) lost_limit_q = csr_wr_data;
         if (rsp_tvalid && rsp_tready) begin
            got = status_type'(rsp_tdata[$bits(status_type)-1:0]);
            if (want_status_q.size() == 0) begin
               flag_mismatch("result with no item pending", int'(rsp_tdata), 0);
            end else begin
               want = want_status_q.pop_front();
               check_status(got, want);
            end
         end
         if (req_tvalid && req_tready) begin
            step_controller(req_tuser, req_tdata[7:0], req_tdata[13:8], want);
            want_status_q.push_back(want);
         end
      end
      outstanding <= want_status_q.size();
   end

endmodule

@@ dv/line_follower_mode_controller_tb.sv @@
`timescale 1ns / 1ps

module line_follower_mode_controller_tb;
   import lfmc_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 80;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic                  req_tuser   = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_wr_en   = 1'b0;
   logic [15:0]           csr_wr_data = '0;

   logic gaps_on   = 1'b1;
   logic stalls_on = 1'b1;
   logic hold_arm  = 1'b0;
   int   hold_left = 0;
   int   quiet_cycles = 0;
   int   outstanding;
   int   fail_count;

   line_follower_mode_controller i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   line_follower_mode_controller_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .outstanding (outstanding),
      .fail_count  (fail_count)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // receiver: random stalls, or a long hold-off once armed
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_arm) begin
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !(stalls_on && $urandom_range(99) < 10);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("line_follower_mode_controller_tb NOT OK");
            $finish;
         end
      end
   end

   task automatic send_item(input logic op, input logic [7:0] sensors, input logic [5:0] bumpers);
      if (gaps_on && $urandom_range(99) < 10) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {2'b00, bumpers, sensors};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_tick(input logic [7:0] sensors);
      send_item(OP_TICK, sensors, 6'($urandom_range(63)));
   endtask

   task automatic send_bumper(input logic [5:0] bumpers);
      send_item(OP_BUMPER, 8'($urandom_range(255)), bumpers);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic set_lost_limit(input logic [15:0] limit);
      wait_drained();
      repeat (3) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= limit;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic random_items(input int n_items);
      int sent;
      int pick;
      int run_len;
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            // start bumper, then a run of dark ticks toward the lost timeout
            run_len = $urandom_range(1, 24);
            send_bumper(BUMPER_START_ONLY);
            repeat (run_len) send_tick(8'h00);
            sent += run_len + 1;
         end else if (pick < 20) begin
            send_bumper(BUMPER_START_ONLY);
            sent++;
         end else if (pick < 26) begin
            send_bumper(6'($urandom_range(63)));
            sent++;
         end else if (pick < 45) begin
            send_tick(8'h00);
            sent++;
         end else begin
            send_tick(8'($urandom_range(255)));
            sent++;
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset limit of 750
      send_tick(8'h00);
      send_tick(8'hFF);
      send_bumper(6'h00);
      send_bumper(BUMPER_START_ONLY);
      send_tick(8'hF0);
      send_tick(8'hF1);
      send_tick(8'h0F);
      send_tick(8'h1F);
      send_tick(8'h11);
      send_tick(8'h31);
      send_tick(8'h00);
      send_tick(8'h00);
      send_tick(8'h80);
      send_bumper(BUMPER_START_ONLY);
      send_bumper(BUMPER_START_ONLY);
      send_tick(8'h00);
      send_bumper(6'h3F);
      send_bumper(6'h20);
      send_bumper(BUMPER_START_ONLY);
      send_tick(8'h00);
      send_bumper(BUMPER_START_ONLY);

      // zero limit: any tick drops back to standby
      set_lost_limit(16'd0);
      send_bumper(BUMPER_START_ONLY);
      send_tick(8'h00);
      send_bumper(BUMPER_START_ONLY);
      send_tick(8'hF0);
      random_items(60);

      set_lost_limit(16'd1);
      random_items(150);

      gaps_on   <= 1'b0;
      stalls_on <= 1'b0;
      set_lost_limit(16'hFFFF);
      random_items(150);
      gaps_on   <= 1'b1;
      stalls_on <= 1'b1;

      // long receiver hold-off while items keep coming
      wait_drained();
      hold_arm <= 1'b1;
      @(posedge clock);
      hold_arm <= 1'b0;
      random_items(30);

      set_lost_limit(16'd2);
      random_items(75);
      wait_drained();
      random_items(75);

      set_lost_limit(16'($urandom_range(3, 30)));
      random_items(150);

      set_lost_limit(16'($urandom_range(3, 12)));
      random_items(120);

      set_lost_limit(LOST_LIMIT_RESET);
      random_items(150);

      wait_drained();
      repeat (4) @(posedge clock);
      if (fail_count == 0) begin
         $display("line_follower_mode_controller_tb OK");
      end else begin
         $display("line_follower_mode_controller_tb NOT OK");
      end
      $finish;
   end

endmodule
